// ===== hw/rtl/assert_macros.svh =====
// Assertion macros for the RTL files that carry checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property must hold at every rising clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// When ante holds, cons must hold in the next cycle.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define ASSERT_ALWAYS(lbl, clk, rst, prop, msg)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)

`endif

`endif

// ===== hw/rtl/ebv_pkg.sv =====
// Shared constants, types and states of the exchange sort block.
package ebv_pkg;

  localparam int VALUE_W       = 32;
  localparam int TAG_W         = 6;
  localparam int DEF_MAX_ITEMS = 64;
  localparam int DEF_KEY_BITS  = 32;
  localparam int QUEUE_DEPTH   = 4;

  // Flags of one front-to-back command.
  typedef struct packed {
    logic wr;    // record is stored
    logic last;  // record closes the group
    logic ovf;   // group has dropped a record so far
  } ebv_flags_t;

  localparam int FLAGS_W = $bits(ebv_flags_t);

  // Status of the back end.
  typedef struct packed {
    logic sorting;  // exchange passes in progress
    logic sending;  // sorted group being streamed out
  } bk_status_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_LOAD,
    BK_HEAD,
    BK_SCAN,
    BK_WB,
    BK_ORD,
    BK_OLD
  } bk_state_t;

endpackage

// ===== hw/rtl/ebv_ifs.sv =====
// Handshake interfaces for the record feed and the sorted result channel.
interface ebv_feed_if
  import ebv_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [VALUE_W-1:0] value;
  logic [TAG_W-1:0]   tag;
  logic               group_end;

  modport source (output valid, value, tag, group_end, input ready);
  modport sink   (input valid, value, tag, group_end, output ready);
endinterface

interface ebv_result_if
  import ebv_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [VALUE_W-1:0] sorted_value;
  logic [TAG_W-1:0]   sorted_tag;
  logic               last_of_run;
  logic               overflowed;

  modport source (output valid, sorted_value, sorted_tag, last_of_run, overflowed,
                  input ready);
  modport sink   (input valid, sorted_value, sorted_tag, last_of_run, overflowed,
                  output ready);
endinterface

// ===== hw/rtl/ebv_front.sv =====
// Front end: accepts records, assigns slots, flags overflow, emits commands.
module ebv_front
  import ebv_pkg::*;
#(
  parameter int MAX_ITEMS = DEF_MAX_ITEMS,
  parameter int KEY_BITS  = DEF_KEY_BITS,
  localparam int KW    = (KEY_BITS < VALUE_W) ? KEY_BITS : VALUE_W,
  localparam int AW    = $clog2(MAX_ITEMS),
  localparam int CW    = $clog2(MAX_ITEMS + 1),
  localparam int CMD_W = FLAGS_W + CW + AW + KW + TAG_W
) (
  input  logic             clk,
  input  logic             rst,
  ebv_feed_if.sink         feed,
  output logic             q_push,
  output logic [CMD_W-1:0] q_data,
  input  logic             q_full
);

  logic [CW-1:0] count;
  logic          ovf;
  logic          store;
  logic [CW-1:0] count_inc;
  ebv_flags_t    flags;

  assign feed.ready = !q_full;
  assign q_push     = feed.valid && !q_full;
  assign store      = (count != CW'(MAX_ITEMS));
  assign count_inc  = store ? count + CW'(1) : count;

  assign flags.wr   = store;
  assign flags.last = feed.group_end;
  assign flags.ovf  = ovf || !store;

  assign q_data = {flags, count_inc, count[AW-1:0], feed.value[KW-1:0], feed.tag};

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      ovf   <= 1'b0;
    end else if (q_push) begin
      if (feed.group_end) begin
        count <= '0;
        ovf   <= 1'b0;
      end else begin
        count <= count_inc;
        ovf   <= flags.ovf;
      end
    end
  end

endmodule

// ===== hw/rtl/ebv_queue.sv =====
// Small register FIFO between front and back ends.
module ebv_queue
  import ebv_pkg::*;
#(
  parameter int W     = 8,
  parameter int DEPTH = QUEUE_DEPTH,
  localparam int PW   = $clog2(DEPTH),
  localparam int NW   = $clog2(DEPTH + 1)
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] push_data,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] pop_data,
  output logic         empty
);

  logic [W-1:0]  slots [DEPTH];
  logic [PW-1:0] wp;
  logic [PW-1:0] rp;
  logic [NW-1:0] used;
  logic          do_push;
  logic          do_pop;

  assign full     = (used == NW'(DEPTH));
  assign empty    = (used == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = slots[rp];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wp] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp   <= '0;
      rp   <= '0;
      used <= '0;
    end else begin
      if (do_push) begin
        wp <= (wp == PW'(DEPTH - 1)) ? '0 : wp + PW'(1);
      end
      if (do_pop) begin
        rp <= (rp == PW'(DEPTH - 1)) ? '0 : rp + PW'(1);
      end
      if (do_push && !do_pop) begin
        used <= used + NW'(1);
      end else if (do_pop && !do_push) begin
        used <= used - NW'(1);
      end
    end
  end

endmodule

// ===== hw/rtl/ebv_back.sv =====
// Back end: record memory, exchange sort sequencer and result register.
module ebv_back
  import ebv_pkg::*;
#(
  parameter int MAX_ITEMS = DEF_MAX_ITEMS,
  parameter int KEY_BITS  = DEF_KEY_BITS,
  localparam int KW    = (KEY_BITS < VALUE_W) ? KEY_BITS : VALUE_W,
  localparam int AW    = $clog2(MAX_ITEMS),
  localparam int CW    = $clog2(MAX_ITEMS + 1),
  localparam int CMD_W = FLAGS_W + CW + AW + KW + TAG_W
) (
  input  logic             clk,
  input  logic             rst,
  output logic             q_pop,
  input  logic [CMD_W-1:0] q_data,
  input  logic             q_empty,
  ebv_result_if.source     result,
  output bk_status_t       status
);

  // command fields
  ebv_flags_t       c_flags;
  logic [CW-1:0]    c_n;
  logic [AW-1:0]    c_addr;
  logic [KW-1:0]    c_key;
  logic [TAG_W-1:0] c_tag;

  assign {c_flags, c_n, c_addr, c_key, c_tag} = q_data;

  // record memory
  logic [KW-1:0]    mem_key [MAX_ITEMS];
  logic [TAG_W-1:0] mem_tag [MAX_ITEMS];
  logic [KW-1:0]    rd_key;
  logic [TAG_W-1:0] rd_tag;

  bk_state_t        state;
  bk_state_t        state_next;
  logic [AW-1:0]    i_idx;
  logic [AW-1:0]    j_idx;
  logic [AW-1:0]    k_idx;
  logic [CW-1:0]    n_cnt;
  logic             grp_ovf;
  logic [KW-1:0]    cur_key;
  logic [TAG_W-1:0] cur_tag;
  logic             out_valid;

  // decode
  logic             rd_en;
  logic [AW-1:0]    rd_addr;
  logic             wr_en;
  logic [AW-1:0]    wr_addr;
  logic [KW-1:0]    wr_key;
  logic [TAG_W-1:0] wr_tag;
  logic             out_load;
  logic             less;
  logic             scan_last;
  logic             more;
  logic             k_last;

  assign less      = (rd_key < cur_key);
  assign scan_last = (CW'(j_idx) == n_cnt - CW'(1));
  assign more      = (CW'(i_idx) + CW'(2) < n_cnt);
  assign k_last    = (CW'(k_idx) == n_cnt - CW'(1));

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_key[wr_addr] <= wr_key;
      mem_tag[wr_addr] <= wr_tag;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_key <= mem_key[rd_addr];
      rd_tag <= mem_tag[rd_addr];
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      BK_IDLE: begin
        if (!q_empty && c_flags.last) begin
          state_next = (c_n == CW'(1)) ? BK_ORD : BK_LOAD;
        end
      end
      BK_LOAD: state_next = BK_HEAD;
      BK_HEAD: state_next = BK_SCAN;
      BK_SCAN: begin
        if (scan_last) begin
          state_next = BK_WB;
        end
      end
      BK_WB:   state_next = more ? BK_HEAD : BK_ORD;
      BK_ORD:  state_next = BK_OLD;
      BK_OLD: begin
        if (out_load) begin
          state_next = k_last ? BK_IDLE : BK_ORD;
        end
      end
      default: state_next = BK_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    q_pop    = 1'b0;
    rd_en    = 1'b0;
    rd_addr  = i_idx;
    wr_en    = 1'b0;
    wr_addr  = c_addr;
    wr_key   = c_key;
    wr_tag   = c_tag;
    out_load = 1'b0;
    unique case (state)
      BK_IDLE: begin
        q_pop = !q_empty;
        wr_en = !q_empty && c_flags.wr;
      end
      BK_LOAD: begin
        rd_en   = 1'b1;
        rd_addr = i_idx;
      end
      BK_HEAD: begin
        rd_en   = 1'b1;
        rd_addr = j_idx;
      end
      BK_SCAN: begin
        wr_en   = less;
        wr_addr = j_idx;
        wr_key  = cur_key;
        wr_tag  = cur_tag;
        rd_en   = !scan_last;
        rd_addr = j_idx + AW'(1);
      end
      BK_WB: begin
        wr_en   = 1'b1;
        wr_addr = i_idx;
        wr_key  = cur_key;
        wr_tag  = cur_tag;
        rd_en   = more;
        rd_addr = i_idx + AW'(1);
      end
      BK_ORD: begin
        rd_en   = 1'b1;
        rd_addr = k_idx;
      end
      BK_OLD: out_load = !out_valid || result.ready;
      default: ;
    endcase
  end

  // sequencer registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= BK_IDLE;
      i_idx   <= '0;
      j_idx   <= '0;
      k_idx   <= '0;
      n_cnt   <= '0;
      grp_ovf <= 1'b0;
    end else begin
      state <= state_next;
      unique case (state)
        BK_IDLE: begin
          if (!q_empty && c_flags.last) begin
            n_cnt   <= c_n;
            grp_ovf <= c_flags.ovf;
            i_idx   <= '0;
            k_idx   <= '0;
          end
        end
        BK_LOAD: j_idx <= i_idx + AW'(1);
        BK_SCAN: j_idx <= j_idx + AW'(1);
        BK_WB: begin
          i_idx <= i_idx + AW'(1);
          j_idx <= i_idx + AW'(2);
        end
        BK_OLD: begin
          if (out_load) begin
            k_idx <= k_idx + AW'(1);
          end
        end
        default: ;
      endcase
    end
  end

  // record held at position i during its pass
  always_ff @(posedge clk) begin
    if (state == BK_HEAD || (state == BK_SCAN && less)) begin
      cur_key <= rd_key;
      cur_tag <= rd_tag;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      result.sorted_value <= VALUE_W'(rd_key);
      result.sorted_tag   <= rd_tag;
      result.last_of_run  <= k_last;
      result.overflowed   <= grp_ovf;
    end
  end

  assign result.valid = out_valid;

  assign status.sorting = (state == BK_LOAD) || (state == BK_HEAD) ||
                          (state == BK_SCAN) || (state == BK_WB);
  assign status.sending = (state == BK_ORD) || (state == BK_OLD);

endmodule

// ===== hw/rtl/exchange_sort_by_value_core.sv =====
// Top level of the exchange sort block: front end, command queue, back end.
//
//   channel  dir  handshake            payload
//   feed     in   feed.valid/ready     value, tag, group_end
//   result   out  result.valid/ready   sorted_value, sorted_tag, last_of_run, overflowed
//
// The front takes one record a cycle, while the queue is not full, into a
// QUEUE_DEPTH command queue; the back writes each record to the record memory
// as it pops it from the queue, which it does only while idle. Each compare
// uses the single read / single write memory port, and each pass adds a head
// read and a write-back. Each result is then read and registered.
// No clearing pass after reset: the record memory is only read where written.
// Feed stalls only when the queue is full; a stalled result holds in place.
`include "assert_macros.svh"

module exchange_sort_by_value_core
  import ebv_pkg::*;
#(
  parameter int MAX_ITEMS = DEF_MAX_ITEMS,
  parameter int KEY_BITS  = DEF_KEY_BITS
) (
  input  logic         clk,
  input  logic         rst,
  ebv_feed_if.sink     feed,
  ebv_result_if.source result
);

  localparam int KW    = (KEY_BITS < VALUE_W) ? KEY_BITS : VALUE_W;
  localparam int AW    = $clog2(MAX_ITEMS);
  localparam int CW    = $clog2(MAX_ITEMS + 1);
  localparam int CMD_W = FLAGS_W + CW + AW + KW + TAG_W;

  // command path: {flags, count, slot, key, tag}
  logic             q_push;
  logic [CMD_W-1:0] q_in;
  logic             q_full;
  logic             q_pop;
  logic [CMD_W-1:0] q_out;
  logic             q_empty;
  bk_status_t       bk_stat;

  // Front: slot assignment and overflow tracking per group.
  ebv_front #(
    .MAX_ITEMS (MAX_ITEMS),
    .KEY_BITS  (KEY_BITS)
  ) u_front (
    .clk    (clk),
    .rst    (rst),
    .feed   (feed),
    .q_push (q_push),
    .q_data (q_in),
    .q_full (q_full)
  );

  // Decouples record intake from the sort.
  ebv_queue #(
    .W     (CMD_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_out),
    .empty     (q_empty)
  );

  // Back: memory, exchange passes, result streaming.
  ebv_back #(
    .MAX_ITEMS (MAX_ITEMS),
    .KEY_BITS  (KEY_BITS)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_pop   (q_pop),
    .q_data  (q_out),
    .q_empty (q_empty),
    .result  (result),
    .status  (bk_stat)
  );

  // Front never pushes into a full queue.
  `ASSERT_ALWAYS(a_no_push_full, clk, rst, !(q_push && q_full), "push into full queue")
  // Back never pops an empty queue.
  `ASSERT_ALWAYS(a_no_pop_empty, clk, rst, !(q_pop && q_empty), "pop from empty queue")
  // Commands wait in the queue while the group is being sorted or sent.
  `ASSERT_ALWAYS(a_no_pop_busy, clk, rst, !((bk_stat.sorting || bk_stat.sending) && q_pop),
                 "queue popped while back end busy")

endmodule
